// ----- sv/tdpc_pkg.sv -----
// shared types, constants and microcode definitions for the trial division prime counter
package tdpc_pkg;

    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 32;
    localparam int PC_W      = 4;
    localparam int DIV_CNT_W = $clog2(VALUE_W);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               end_of_data;
    } item_t;

    typedef struct packed {
        logic               prime_flag;
        logic [COUNT_W-1:0] count_so_far;
        logic               final_res;
    } result_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_START,
        OP_STEP_D,
        OP_EMIT_PRIME,
        OP_EMIT_COMP,
        OP_EMIT_END
    } op_t;

    // stall conditions: the step repeats, with no operation, while it holds
    typedef enum logic [1:0] {
        W_NONE,
        W_IN_EMPTY,
        W_DIV_BUSY,
        W_OUT_FULL
    } wait_t;

    // branch conditions
    typedef enum logic [2:0] {
        B_NEVER,
        B_ALWAYS,
        B_EOD,
        B_LE_ONE,
        B_IS_TWO,
        B_EVEN,
        B_D_GT_Q,
        B_REM_ZERO
    } branch_t;

    typedef struct packed {
        op_t             op;
        wait_t           wt;
        branch_t         br;
        logic [PC_W-1:0] target;
    } ucode_t;

    // step addresses
    localparam logic [PC_W-1:0] PC_FETCH      = PC_W'(0);
    localparam logic [PC_W-1:0] PC_CHK_EOD    = PC_W'(1);
    localparam logic [PC_W-1:0] PC_CHK_SMALL  = PC_W'(2);
    localparam logic [PC_W-1:0] PC_CHK_TWO    = PC_W'(3);
    localparam logic [PC_W-1:0] PC_CHK_EVEN   = PC_W'(4);
    localparam logic [PC_W-1:0] PC_DIV        = PC_W'(5);
    localparam logic [PC_W-1:0] PC_DIV_WAIT   = PC_W'(6);
    localparam logic [PC_W-1:0] PC_CHK_REM    = PC_W'(7);
    localparam logic [PC_W-1:0] PC_LOOP       = PC_W'(8);
    localparam logic [PC_W-1:0] PC_EMIT_PRIME = PC_W'(9);
    localparam logic [PC_W-1:0] PC_EMIT_COMP  = PC_W'(10);
    localparam logic [PC_W-1:0] PC_EMIT_END   = PC_W'(11);

    // status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic div_busy;
        logic out_full;
        logic eod;
        logic le_one;
        logic is_two;
        logic even;
        logic d_gt_q;
        logic rem_zero;
    } status_t;

    // control from the sequencer to the datapath
    typedef struct packed {
        op_t  cmd;
        logic fetch;
    } ctrl_t;

endpackage

// ----- sv/trial_division_prime_counter.sv -----
// top level of the trial division prime counter: datapath, divider and sequencer
//
// item channel (item_valid, item_ready, item): one number to test, or an
// end-of-data item that reports the running prime count and clears it.
// result channel (result_valid, result_ready, result): exactly one result per
// item, in order: prime flag, count including this item, end-of-data mark.
// an end-of-data item, 0, 1, 2 or an even number is settled by the check
// steps alone. an odd number runs one trial per odd divisor from 3 upward
// until a divisor divides it or a divisor's square exceeds it; each trial is
// one pass of the single bit-serial divider plus 4 control steps.
// only one item is in work at a time: item_ready is high in the fetch step.
// the result sits in an output register, so a new item is taken while the
// previous result still waits; if the receiver stalls, the sequencer holds in
// its emit step until the register frees up.
// reset clears the step counter, the prime count and the output valid flag;
// the count saturates at all ones.
module trial_division_prime_counter
    import tdpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    // datapath registers
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               eod_reg, eod_next;
    logic [VALUE_W-1:0] div_reg, div_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic [COUNT_W-1:0] count_inc;
    logic               div_busy;
    logic [VALUE_W-1:0] quotient;
    logic [VALUE_W-1:0] remainder;
    status_t            status;
    ctrl_t              ctrl;

    tdpc_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctrl.cmd == OP_DIV_START),
        .dividend  (value_reg),
        .divisor   (div_reg),
        .busy      (div_busy),
        .quotient  (quotient),
        .remainder (remainder)
    );

    tdpc_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // status flags for the branch conditions
    always_comb
    begin
        status.in_valid = item_valid;
        status.div_busy = div_busy;
        status.out_full = out_valid_reg && !result_ready;
        status.eod      = eod_reg;
        status.le_one   = (value_reg[VALUE_W-1:1] == '0);
        status.is_two   = (value_reg == VALUE_W'(2));
        status.even     = !value_reg[0];
        // divisor above the quotient means divisor squared exceeds the value
        status.d_gt_q   = (div_reg > quotient);
        status.rem_zero = (remainder == '0);
    end

    // saturating increment
    assign count_inc = (&count_reg) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        value_next     = value_reg;
        eod_next       = eod_reg;
        div_next       = div_reg;
        count_next     = count_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;
        case (ctrl.cmd)
            OP_LOAD:
            begin
                value_next = item.value;
                eod_next   = item.end_of_data;
                div_next   = VALUE_W'(3);
            end
            OP_STEP_D:
            begin
                div_next = div_reg + VALUE_W'(2);
            end
            OP_EMIT_PRIME:
            begin
                count_next     = count_inc;
                out_next       = '{1'b1, count_inc, 1'b0};
                out_valid_next = 1'b1;
            end
            OP_EMIT_COMP:
            begin
                out_next       = '{1'b0, count_reg, 1'b0};
                out_valid_next = 1'b1;
            end
            OP_EMIT_END:
            begin
                // report the final count, then start a fresh stream
                count_next     = '0;
                out_next       = '{1'b0, count_reg, 1'b1};
                out_valid_next = 1'b1;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        eod_reg   <= eod_next;
        div_reg   <= div_next;
        out_reg   <= out_next;
    end

    assign item_ready   = ctrl.fetch;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- sv/tdpc_divider.sv -----
// iterative restoring divider, one quotient bit per cycle
module tdpc_divider
    import tdpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] dividend,
    input  logic [VALUE_W-1:0] divisor,
    output logic               busy,
    output logic [VALUE_W-1:0] quotient,
    output logic [VALUE_W-1:0] remainder
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic [VALUE_W-1:0]   quo_reg, quo_next;
    logic [VALUE_W-1:0]   rem_reg, rem_next;
    logic [VALUE_W-1:0]   dsr_reg, dsr_next;
    logic [VALUE_W:0]     trial;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[VALUE_W-1]} - {1'b0, dsr_reg};
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = DIV_CNT_W'(VALUE_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial[VALUE_W])
            begin
                rem_next = {rem_reg[VALUE_W-2:0], quo_reg[VALUE_W-1]};
                quo_next = {quo_reg[VALUE_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[VALUE_W-1:0];
                quo_next = {quo_reg[VALUE_W-2:0], 1'b1};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- sv/tdpc_sequencer.sv -----
// microcode store and step counter with stall and branch conditions
module tdpc_sequencer
    import tdpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl
);

    logic [PC_W-1:0] pc_reg, pc_next;
    ucode_t          uw;
    logic            stall;
    logic            take;

    // control store
    always_comb
    begin
        case (pc_reg)
            PC_FETCH:      uw = '{OP_LOAD,       W_IN_EMPTY, B_NEVER,    PC_FETCH};
            PC_CHK_EOD:    uw = '{OP_NOP,        W_NONE,     B_EOD,      PC_EMIT_END};
            PC_CHK_SMALL:  uw = '{OP_NOP,        W_NONE,     B_LE_ONE,   PC_EMIT_COMP};
            PC_CHK_TWO:    uw = '{OP_NOP,        W_NONE,     B_IS_TWO,   PC_EMIT_PRIME};
            PC_CHK_EVEN:   uw = '{OP_NOP,        W_NONE,     B_EVEN,     PC_EMIT_COMP};
            PC_DIV:        uw = '{OP_DIV_START,  W_NONE,     B_NEVER,    PC_FETCH};
            PC_DIV_WAIT:   uw = '{OP_NOP,        W_DIV_BUSY, B_D_GT_Q,   PC_EMIT_PRIME};
            PC_CHK_REM:    uw = '{OP_STEP_D,     W_NONE,     B_REM_ZERO, PC_EMIT_COMP};
            PC_LOOP:       uw = '{OP_NOP,        W_NONE,     B_ALWAYS,   PC_DIV};
            PC_EMIT_PRIME: uw = '{OP_EMIT_PRIME, W_OUT_FULL, B_ALWAYS,   PC_FETCH};
            PC_EMIT_COMP:  uw = '{OP_EMIT_COMP,  W_OUT_FULL, B_ALWAYS,   PC_FETCH};
            PC_EMIT_END:   uw = '{OP_EMIT_END,   W_OUT_FULL, B_ALWAYS,   PC_FETCH};
            default:       uw = '{OP_NOP,        W_NONE,     B_ALWAYS,   PC_FETCH};
        endcase
    end

    always_comb
    begin
        case (uw.wt)
            W_IN_EMPTY: stall = !status.in_valid;
            W_DIV_BUSY: stall = status.div_busy;
            W_OUT_FULL: stall = status.out_full;
            default:    stall = 1'b0;
        endcase

        case (uw.br)
            B_ALWAYS:   take = 1'b1;
            B_EOD:      take = status.eod;
            B_LE_ONE:   take = status.le_one;
            B_IS_TWO:   take = status.is_two;
            B_EVEN:     take = status.even;
            B_D_GT_Q:   take = status.d_gt_q;
            B_REM_ZERO: take = status.rem_zero;
            default:    take = 1'b0;
        endcase

        if (stall)
        begin
            pc_next  = pc_reg;
            ctrl.cmd = OP_NOP;
        end
        else
        begin
            pc_next  = take ? uw.target : pc_reg + 1'b1;
            ctrl.cmd = uw.op;
        end
        ctrl.fetch = (uw.op == OP_LOAD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- verif/trial_division_prime_counter_tb.sv -----
// self-checking testbench for the trial division prime counter
module trial_division_prime_counter_tb;
    import tdpc_pkg::*;

    // run length and pacing
    localparam int unsigned CYCLE_LIMIT  = 5_000_000;
    localparam int unsigned RANDOM_ITEMS = 280;
    localparam int unsigned CALM_TAIL    = 40;
    localparam int unsigned LONG_HOLD    = 2000;
    localparam int unsigned DRAIN_CYCLES = 16;

    // running prime tally and the results it predicts, oldest first
    class prime_tally_board;
        logic [COUNT_W-1:0] tally;
        result_t            awaited[$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        numbers;
        int unsigned        primes;
        int unsigned        reports;

        function new();
            tally   = '0;
            errors  = 0;
            checked = 0;
            numbers = 0;
            primes  = 0;
            reports = 0;
        endfunction

        // odd trial divisors from 3 while d*d does not exceed n
        static function bit prime_by_trial(logic [VALUE_W-1:0] n);
            longint unsigned v;
            longint unsigned d;
            v = n;
            if (v <= 1)
                return 1'b0;
            if (v == 2)
                return 1'b1;
            if (v[0] == 1'b0)
                return 1'b0;
            for (d = 3; d <= v / d; d += 2)
                if (v % d == 0)
                    return 1'b0;
            return 1'b1;
        endfunction

        function void note_item(item_t it);
            result_t want;
            if (it.end_of_data)
            begin
                // report the count, then start a fresh stream
                want.prime_flag   = 1'b0;
                want.count_so_far = tally;
                want.final_res    = 1'b1;
                tally             = '0;
                reports++;
            end
            else
            begin
                want.prime_flag = prime_by_trial(it.value);
                if (want.prime_flag && tally != '1)
                    tally = tally + 1'b1;
                want.count_so_far = tally;
                want.final_res    = 1'b0;
                numbers++;
                if (want.prime_flag)
                    primes++;
            end
            awaited.push_back(want);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected result: flag %0b count %0d end %0b",
                             got.prime_flag, got.count_so_far, got.final_res);
                errors++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.prime_flag !== want.prime_flag ||
                got.count_so_far !== want.count_so_far ||
                got.final_res !== want.final_res)
            begin
                if (errors < 10)
                    $display("result %0d: expected %0b/%0d/%0b got %0b/%0d/%0b (flag/count/end)",
                             checked, want.prime_flag, want.count_so_far, want.final_res,
                             got.prime_flag, got.count_so_far, got.final_res);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        function bit failed();
            return errors != 0 || awaited.size() != 0;
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    prime_tally_board board;

    // shared between the sender, the receiver and the main sequence
    bit          idling_on    = 1'b1;
    int unsigned hold_request = 0;
    int unsigned holds_done   = 0;

    trial_division_prime_counter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // 8-unit clock period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // handshakes are sampled at the edge, before the block updates its outputs
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (item_valid && item_ready)
                board.note_item(item);
            if (result_valid && result_ready)
                board.check_result(result);
        end
    end

    // offer one item and hold it until the block takes it; while idling is on, at times a random gap first
    task automatic send_item(input logic [VALUE_W-1:0] v, input logic eod);
        item_t it;
        it.value       = v;
        it.end_of_data = eod;
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    // mostly small, as a prime's trial loop grows with sqrt(n); large ones are
    // even or multiples of three, settled by the even check or the first trial
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned        sel;
        logic [VALUE_W-1:0] r;
        sel = $urandom_range(0, 99);
        r   = $urandom;
        if (sel < 55)
            return VALUE_W'($urandom_range(0, 1023));
        else if (sel < 80)
            return VALUE_W'($urandom_range(1024, 16383));
        else if (sel < 90)
            return r & ~VALUE_W'(1);
        else
            return r - (r % 3);
    endfunction

    // wait until every predicted result has come back; at least one edge first
    // so that an item taken at the current edge is already noted
    task automatic drain_results();
        do
            @(posedge clk);
        while (board.outstanding() != 0);
    endtask

    // receiver: random stall bursts, or one long hold when asked
    initial
    begin
        result_ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_request != 0)
            begin
                result_ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
                holds_done++;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int unsigned random_sent;
        int unsigned stream_len;
        int unsigned k;

        board      = new();
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty stream, the small special values, squares of odd primes
        send_item('0, 1'b1);
        send_item(VALUE_W'(0), 1'b0);
        send_item(VALUE_W'(1), 1'b0);
        send_item(VALUE_W'(2), 1'b0);
        send_item(VALUE_W'(3), 1'b0);
        send_item(VALUE_W'(4), 1'b0);
        send_item(VALUE_W'(5), 1'b0);
        send_item(VALUE_W'(9), 1'b0);
        send_item(VALUE_W'(25), 1'b0);
        send_item(VALUE_W'(49), 1'b0);
        send_item('0, 1'b1);
        // divisor squared lands exactly on the value, or just past a factor
        send_item(VALUE_W'(63001), 1'b0);
        send_item(VALUE_W'(64507), 1'b0);
        // largest primes below 2^16 and 2^24: long trial loops
        send_item(VALUE_W'(65521), 1'b0);
        send_item(VALUE_W'(16777213), 1'b0);
        // extremes of the value field
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'hFFFF_FFFE, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        // end of data with a value that must be ignored, then back to back
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(VALUE_W'(7), 1'b1);

        // long receiver hold: the output register fills and item_ready drops
        idling_on    = 1'b0;
        hold_request = LONG_HOLD;
        for (k = 0; k < 6; k++)
            send_item(VALUE_W'($urandom_range(0, 255)), 1'b0);
        send_item('0, 1'b1);

        // sender pause until the block has handed back everything
        item_valid <= 1'b0;
        drain_results();

        // random streams of numbers closed by end of data; some stay open,
        // some are empty, and the last stretch runs with no idling
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            idling_on  = (random_sent + CALM_TAIL < RANDOM_ITEMS) &&
                         ($urandom_range(0, 3) != 0);
            stream_len = $urandom_range(0, 20);
            for (k = 0; k < stream_len; k++)
            begin
                send_item(pick_value(), 1'b0);
                random_sent++;
            end
            if ($urandom_range(0, 7) != 0)
            begin
                send_item($urandom_range(0, 1) ? VALUE_W'($urandom) : '0, 1'b1);
                random_sent++;
            end
        end

        // close the last stream, then let everything settle
        send_item('0, 1'b1);
        item_valid <= 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.outstanding() != 0)
            $display("%0d expected results never arrived", board.outstanding());
        $display("covered %0d numbers (%0d prime), %0d end-of-data reports, %0d long hold(s)",
                 board.numbers, board.primes, board.reports, holds_done);
        $display("checked %0d results, %0d errors", board.checked, board.errors);
        if (!board.failed())
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
